@@ rtl/core/rdc_pkg.sv @@
// shared types, constants and helpers for the radix digit converter
`timescale 1ns / 1ps

package rdc_pkg;

  // value and store sizes
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned MAX_DIGITS = 32;
  localparam int unsigned DIV_W      = VALUE_W - 1;
  localparam int unsigned STEP_W     = $clog2(DIV_W);
  localparam int unsigned ADDR_W     = $clog2(MAX_DIGITS);
  localparam int unsigned COUNT_W    = $clog2(MAX_DIGITS + 1);

  // digit and radix fields
  localparam int unsigned RADIX_W  = 6;
  localparam int unsigned DIGIT_W  = 6;
  localparam int unsigned GLYPH_W  = 7;
  localparam int unsigned STATUS_W = 2;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [DIGIT_W-1:0] DEC_DIGITS  = DIGIT_W'(10);
  localparam logic [GLYPH_W-1:0] CHAR_ZERO   = GLYPH_W'(48);
  localparam logic [GLYPH_W-1:0] CHAR_A      = GLYPH_W'(65);

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_RADIX = 2'd1,
    ST_NEGATIVE  = 2'd2
  } status_e;

  // divider request and response
  typedef struct packed {
    logic               start;
    logic [DIV_W-1:0]   dividend;
    logic [RADIX_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_W-1:0]   quot;
    logic [RADIX_W-1:0] rem;
  } div_resp_t;

  // ascii character of a digit
  function automatic logic [GLYPH_W-1:0] glyph_of(input logic [DIGIT_W-1:0] d);
    logic [GLYPH_W-1:0] g;
    if (d < DEC_DIGITS) begin
      g = CHAR_ZERO + GLYPH_W'(d);
    end else begin
      g = CHAR_A + GLYPH_W'(d - DEC_DIGITS);
    end
    return g;
  endfunction

endpackage

@@ rtl/core/rdc_divider.sv @@
// bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module rdc_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rdc_pkg::div_req_t  req_i,
  output rdc_pkg::div_resp_t resp_o
);
  import rdc_pkg::*;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [DIV_W-1:0]   quot_q, quot_d;
  logic [RADIX_W-1:0] rem_q, rem_d;
  logic [RADIX_W-1:0] divisor_q, divisor_d;
  logic [RADIX_W:0]   trial;
  logic [RADIX_W:0]   diff;
  logic               fits;

  // one shift-compare-subtract step
  assign trial = {rem_q, quot_q[DIV_W-1]};
  assign diff  = trial - {1'b0, divisor_q};
  assign fits  = trial >= {1'b0, divisor_q};

  // step sequencing
  always_comb begin
    busy_d    = busy_q;
    done_d    = 1'b0;
    step_d    = step_q;
    quot_d    = quot_q;
    rem_d     = rem_q;
    divisor_d = divisor_q;
    if (req_i.start) begin
      busy_d    = 1'b1;
      step_d    = '0;
      quot_d    = req_i.dividend;
      rem_d     = '0;
      divisor_d = req_i.divisor;
    end else if (busy_q) begin
      quot_d = {quot_q[DIV_W-2:0], fits};
      rem_d  = fits ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
      step_d = step_q + 1'b1;
      if (step_q == STEP_W'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    quot_q    <= quot_d;
    rem_q     <= rem_d;
    divisor_q <= divisor_d;
  end

  assign resp_o.done = done_q;
  assign resp_o.quot = quot_q;
  assign resp_o.rem  = rem_q;

`ifndef SYNTH
  // a new division never cuts into one under way
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider started while busy");

  // completion follows a busy period
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider done without a division");
`endif

endmodule

@@ rtl/core/rdc_digit_store.sv @@
// digit store: one write port and one registered read port
`timescale 1ns / 1ps

module rdc_digit_store (
  input  logic                        clk_i,
  input  logic                        wr_en_i,
  input  logic [rdc_pkg::ADDR_W-1:0]  wr_addr_i,
  input  logic [rdc_pkg::DIGIT_W-1:0] wr_data_i,
  input  logic                        rd_en_i,
  input  logic [rdc_pkg::ADDR_W-1:0]  rd_addr_i,
  output logic [rdc_pkg::DIGIT_W-1:0] rd_data_o
);
  import rdc_pkg::*;

  logic [DIGIT_W-1:0] mem_q [MAX_DIGITS];
  logic [DIGIT_W-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/core/radix_digit_converter.sv @@
// radix digit converter: sequencer around the shared divider and digit store
// each digit takes a full division in the divider; the digits are then read back from the store and emitted
// the largest value has 31 digits in radix 2
// error results (bad radix, negative value) go through the flag state to the output registers, held by out_stall
// one value at a time: the divider loop, emission and output stalls set the rate, input stalls until emission ends
// asynchronous active-low reset clears control state and sets radix to 10
`timescale 1ns / 1ps

module radix_digit_converter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [rdc_pkg::RADIX_W-1:0]  cfg_radix_i,
  // input beats
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [rdc_pkg::VALUE_W-1:0] value_i,
  // result beats
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [rdc_pkg::DIGIT_W-1:0]  digit_o,
  output logic [rdc_pkg::GLYPH_W-1:0]  glyph_o,
  output logic                         last_o,
  output logic [rdc_pkg::STATUS_W-1:0] status_o
);
  import rdc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_READ = 5'b00100,
    S_LOAD = 5'b01000,
    S_FLAG = 5'b10000
  } state_e;

  state_e             state_q, state_d;
  logic [RADIX_W-1:0] radix_q;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [COUNT_W-1:0] count_inc;
  logic [ADDR_W-1:0]  idx_q, idx_d;
  status_e            flag_q, flag_d;

  logic               out_valid_q, out_valid_d;
  logic [DIGIT_W-1:0] digit_q, digit_d;
  logic [GLYPH_W-1:0] glyph_q, glyph_d;
  logic               last_q, last_d;
  status_e            status_q, status_d;

  div_req_t           div_req;
  div_resp_t          div_resp;
  logic               wr_en;
  logic               rd_en;
  logic [DIGIT_W-1:0] rd_data;
  logic               in_beat;
  logic               out_free;
  logic               radix_bad;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_beat     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign radix_bad   = (radix_q < RADIX_MIN) || (radix_q > RADIX_MAX);
  assign count_inc   = count_q + 1'b1;
  assign wr_en       = (state_q == S_DIV) && div_resp.done;
  assign rd_en       = (state_q == S_READ);

  // radix register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      radix_q <= cfg_radix_i;
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    flag_d      = flag_q;
    out_valid_d = out_valid_q && out_stall_i;
    digit_d     = digit_q;
    glyph_d     = glyph_q;
    last_d      = last_q;
    status_d    = status_q;
    div_req     = '{start: 1'b0, dividend: div_resp.quot, divisor: radix_q};
    unique case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          priority if (radix_bad) begin
            flag_d  = ST_BAD_RADIX;
            state_d = S_FLAG;
          end else if (value_i[VALUE_W-1]) begin
            flag_d  = ST_NEGATIVE;
            state_d = S_FLAG;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = value_i[DIV_W-1:0];
            count_d          = '0;
            state_d          = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_resp.done) begin
          count_d = count_inc;
          if ((div_resp.quot != '0) && (count_inc < COUNT_W'(MAX_DIGITS))) begin
            div_req.start = 1'b1;
          end else begin
            idx_d   = count_q[ADDR_W-1:0];
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        state_d = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          digit_d     = rd_data;
          glyph_d     = glyph_of(rd_data);
          last_d      = (idx_q == '0);
          status_d    = ST_OK;
          if (idx_q == '0) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q - 1'b1;
            state_d = S_READ;
          end
        end
      end
      S_FLAG: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          digit_d     = '0;
          glyph_d     = '0;
          last_d      = 1'b1;
          status_d    = flag_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    flag_q   <= flag_d;
    digit_q  <= digit_d;
    glyph_q  <= glyph_d;
    last_q   <= last_d;
    status_q <= status_d;
  end

  // shared divider
  rdc_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .resp_o (div_resp)
  );

  // remainders, least significant first
  rdc_digit_store u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (count_q[ADDR_W-1:0]),
    .wr_data_i (div_resp.rem),
    .rd_en_i   (rd_en),
    .rd_addr_i (idx_q),
    .rd_data_o (rd_data)
  );

  assign out_valid_o = out_valid_q;
  assign digit_o     = digit_q;
  assign glyph_o     = glyph_q;
  assign last_o      = last_q;
  assign status_o    = status_q;

`ifndef SYNTH
  // digit count stays within the store
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (count_q < COUNT_W'(MAX_DIGITS)))
    else $error("digit store overrun");

  // loading the final digit returns the sequencer to idle
  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD) && out_free && (idx_q == '0) |=> (state_q == S_IDLE))
    else $error("sequencer did not finish after last digit");

  // error results carry no digit
  a_flag_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> last_o && (digit_o == '0) && (glyph_o == '0))
    else $error("error beat carries digit data");
`endif

endmodule

@@ bench/testbench.sv @@
// self-checking testbench for the radix digit converter
`timescale 1ns / 1ps

module testbench;
  import rdc_pkg::*;

  localparam int unsigned HALF_PERIOD   = 5;
  localparam int unsigned RESET_CYCLES  = 12;
  localparam int unsigned QUIET_LIMIT   = 10000;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned PHASES        = 15;
  localparam int unsigned PHASE_ITEMS   = 20;
  localparam int unsigned CALM_PHASES   = 2;
  localparam int unsigned HOLD_PHASE    = 4;
  localparam int unsigned PAUSE_PHASE   = 7;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned BURST_MAX     = 13;

  // one result beat as the block presents it
  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic [GLYPH_W-1:0] glyph;
    logic               last;
    status_e            status;
  } digit_beat_t;

  // directed stimulus row: a radix write or a value, with an optional fixed answer
  typedef struct {
    bit                 is_radix;
    logic [VALUE_W-1:0] data;
    bit                 fixed;
    digit_beat_t        want;
  } stim_row_t;

  logic                        clk       = 1'b0;
  logic                        rst_n     = 1'b0;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [RADIX_W-1:0]          cfg_radix = '0;
  logic                        in_valid  = 1'b0;
  logic                        in_stall;
  logic signed [VALUE_W-1:0]   value     = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [DIGIT_W-1:0]          digit;
  logic [GLYPH_W-1:0]          glyph;
  logic                        last_flag;
  logic [STATUS_W-1:0]         status;

  // expected digits in arrival order, and the radix the block holds
  digit_beat_t        pending_digits[$];
  logic [RADIX_W-1:0] radix_now = RADIX_RESET;
  string              digit_chars = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";

  bit                 fixed_armed = 1'b0;
  digit_beat_t        fixed_want;
  stim_row_t          directed_rows[$];

  int unsigned        quiet_cycles = 0;
  int unsigned        fails        = 0;
  bit                 calm         = 1'b0;
  int unsigned        idle_pct     = 0;
  bit                 hold_req     = 1'b0;
  int unsigned        hold_left    = 0;
  int unsigned        stall_left   = 0;

  always #(HALF_PERIOD) clk = ~clk;

  radix_digit_converter u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_radix_i (cfg_radix),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .value_i     (value),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .digit_o     (digit),
    .glyph_o     (glyph),
    .last_o      (last_flag),
    .status_o    (status)
  );

  // work out the digit beats one value gives at radix r
  function automatic void convert_to_digits(input logic [VALUE_W-1:0] v,
                                            input logic [RADIX_W-1:0] r);
    logic [DIGIT_W-1:0] lsd_first[$];
    logic [VALUE_W-1:0] quot;
    digit_beat_t        beat;
    int                 k;
    beat = '0;
    beat.last = 1'b1;
    // radix range is checked before the sign
    if (r < RADIX_MIN || r > RADIX_MAX) begin
      beat.status = ST_BAD_RADIX;
      pending_digits.push_back(beat);
      return;
    end
    if (v[VALUE_W-1]) begin
      beat.status = ST_NEGATIVE;
      pending_digits.push_back(beat);
      return;
    end
    quot = v;
    if (quot == 0) lsd_first.push_back('0);
    while (quot != 0 && lsd_first.size() < MAX_DIGITS) begin
      lsd_first.push_back(DIGIT_W'(quot % r));
      quot = quot / r;
    end
    // emit most significant first
    for (k = lsd_first.size() - 1; k >= 0; k--) begin
      beat.digit  = lsd_first[k];
      beat.glyph  = GLYPH_W'(digit_chars[lsd_first[k]]);
      beat.last   = (k == 0);
      beat.status = ST_OK;
      pending_digits.push_back(beat);
    end
  endfunction

  function automatic void check_field(input string name, input logic [GLYPH_W-1:0] want,
                                      input logic [GLYPH_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fails++;
    end
  endfunction

  function automatic void add_row(input bit is_radix, input logic [VALUE_W-1:0] data,
                                  input bit fixed, input logic [DIGIT_W-1:0] d,
                                  input logic [GLYPH_W-1:0] g, input status_e s);
    stim_row_t row;
    row.is_radix    = is_radix;
    row.data        = data;
    row.fixed       = fixed;
    row.want.digit  = d;
    row.want.glyph  = g;
    row.want.last   = 1'b1;
    row.want.status = s;
    directed_rows.push_back(row);
  endfunction

  // beat monitor: book input beats first, then check result beats
  always @(posedge clk) begin
    digit_beat_t got;
    digit_beat_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        if (fixed_armed) pending_digits.push_back(fixed_want);
        else convert_to_digits(value, radix_now);
      end
      if (cfg_valid && cfg_ready) radix_now = cfg_radix;
      if (out_valid && !out_stall) begin
        got.digit  = digit;
        got.glyph  = glyph;
        got.last   = last_flag;
        got.status = status_e'(status);
        if (pending_digits.size() == 0) begin
          $display("%0t: unexpected beat, expected none, got digit %0d glyph %0d last %0d status %0d",
                   $time, got.digit, got.glyph, got.last, got.status);
          fails++;
        end else begin
          want = pending_digits.pop_front();
          check_field("digit", GLYPH_W'(want.digit), GLYPH_W'(got.digit));
          check_field("glyph", want.glyph, got.glyph);
          check_field("last", GLYPH_W'(want.last), GLYPH_W'(got.last));
          check_field("status", GLYPH_W'(want.status), GLYPH_W'(got.status));
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
      end
    end
  end

  // result side back-pressure: one long hold on request, else random bursts
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (!calm && $urandom_range(99) < idle_pct) begin
      stall_left = $urandom_range(1, BURST_MAX) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // offer one value beat, with an optional gap first; returns once accepted
  task automatic send_value(input logic [VALUE_W-1:0] v, input bit fixed,
                            input digit_beat_t want);
    int unsigned gap;
    @(negedge clk);
    if (!calm && $urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, BURST_MAX);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    value       <= v;
    fixed_armed = fixed;
    fixed_want  = want;
    do @(posedge clk); while (in_stall);
  endtask

  // stop offering and wait for every outstanding digit
  task automatic await_all_digits();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_digits.size() != 0) @(negedge clk);
  endtask

  task automatic write_radix(input logic [RADIX_W-1:0] r);
    await_all_digits();
    cfg_valid <= 1'b1;
    cfg_radix <= r;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // watchdog on cycles with no beat moving
  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    digit_beat_t        none;
    stim_row_t          row;
    logic [VALUE_W-1:0] v;
    logic [RADIX_W-1:0] r;
    int unsigned        idx;
    int unsigned        ph;
    int unsigned        n;
    none = '0;

    // default radix 10: zero, a single digit, ten, the largest value, negatives
    add_row(1'b0, 32'd0, 1'b1, 6'd0, 7'd48, ST_OK);
    add_row(1'b0, 32'd7, 1'b1, 6'd7, 7'd55, ST_OK);
    add_row(1'b0, 32'h7fff_ffff, 1'b0, '0, '0, ST_OK);
    add_row(1'b0, 32'd10, 1'b0, '0, '0, ST_OK);
    add_row(1'b0, 32'hffff_ffff, 1'b1, 6'd0, 7'd0, ST_NEGATIVE);
    add_row(1'b0, 32'h8000_0000, 1'b1, 6'd0, 7'd0, ST_NEGATIVE);
    // lowest radix: longest digit strings
    add_row(1'b1, VALUE_W'(RADIX_MIN), 1'b0, '0, '0, ST_OK);
    add_row(1'b0, 32'h7fff_ffff, 1'b0, '0, '0, ST_OK);
    add_row(1'b0, 32'd1, 1'b1, 6'd1, 7'd49, ST_OK);
    add_row(1'b0, 32'd0, 1'b1, 6'd0, 7'd48, ST_OK);
    add_row(1'b0, 32'h4000_0000, 1'b0, '0, '0, ST_OK);
    // highest radix: letter glyphs up to Z
    add_row(1'b1, VALUE_W'(RADIX_MAX), 1'b0, '0, '0, ST_OK);
    add_row(1'b0, 32'd35, 1'b1, 6'd35, 7'd90, ST_OK);
    add_row(1'b0, 32'd10, 1'b1, 6'd10, 7'd65, ST_OK);
    add_row(1'b0, 32'd36, 1'b0, '0, '0, ST_OK);
    add_row(1'b0, 32'h7fff_ffff, 1'b0, '0, '0, ST_OK);
    // out of range radix, which wins over a negative value
    add_row(1'b1, 32'd0, 1'b0, '0, '0, ST_OK);
    add_row(1'b0, 32'd12345, 1'b1, 6'd0, 7'd0, ST_BAD_RADIX);
    add_row(1'b0, 32'h8000_0000, 1'b1, 6'd0, 7'd0, ST_BAD_RADIX);
    add_row(1'b1, 32'd1, 1'b0, '0, '0, ST_OK);
    add_row(1'b0, 32'd0, 1'b1, 6'd0, 7'd0, ST_BAD_RADIX);
    add_row(1'b1, 32'd37, 1'b0, '0, '0, ST_OK);
    add_row(1'b0, 32'h7fff_ffff, 1'b1, 6'd0, 7'd0, ST_BAD_RADIX);
    add_row(1'b1, 32'd63, 1'b0, '0, '0, ST_OK);
    add_row(1'b0, 32'hffff_ffff, 1'b1, 6'd0, 7'd0, ST_BAD_RADIX);
    // hex with mixed bit patterns
    add_row(1'b1, 32'd16, 1'b0, '0, '0, ST_OK);
    add_row(1'b0, 32'h0fed_cba9, 1'b0, '0, '0, ST_OK);
    add_row(1'b0, 32'h5555_aaaa, 1'b0, '0, '0, ST_OK);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part
    idle_pct = 20;
    for (idx = 0; idx < directed_rows.size(); idx++) begin
      row = directed_rows[idx];
      if (row.is_radix) write_radix(row.data[RADIX_W-1:0]);
      else send_value(row.data, row.fixed, row.want);
    end

    // random phases, each under its own radix and idling level
    for (ph = 0; ph < PHASES; ph++) begin
      calm = (ph >= PHASES - CALM_PHASES);
      idle_pct = (ph % 3 == 0) ? 0 : $urandom_range(10, 50);
      case ($urandom_range(0, 9))
        0: r = RADIX_MIN;
        1: r = RADIX_MAX;
        2: r = $urandom_range(0, 1) ? RADIX_W'($urandom_range(0, 1))
                                    : RADIX_W'($urandom_range(37, 63));
        default: r = RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
      endcase
      write_radix(r);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // long receiver hold while values keep coming, and one full pause
        if (ph == HOLD_PHASE && n == 3) hold_req = 1'b1;
        if (ph == PAUSE_PHASE && n == PHASE_ITEMS / 2) await_all_digits();
        case ($urandom_range(0, 9))
          0, 1: v = $urandom;
          2: begin
            case ($urandom_range(0, 4))
              0: v = '0;
              1: v = 32'h7fff_ffff;
              2: v = 32'h8000_0000;
              3: v = VALUE_W'(r) - 1;
              default: v = VALUE_W'(r) * VALUE_W'(r);
            endcase
          end
          default: begin
            v = $urandom >> $urandom_range(0, 30);
            v[VALUE_W-1] = 1'b0;
          end
        endcase
        send_value(v, 1'b0, none);
      end
    end

    await_all_digits();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fails == 0 && pending_digits.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/rdc_pkg.sv
rtl/core/rdc_divider.sv
rtl/core/rdc_digit_store.sv
rtl/core/radix_digit_converter.sv
bench/testbench.sv
